[rtl/core/imufr_pkg.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation package
// Shared register map, configuration type and fixed constants.
// ----------------------------------------------------------------------------
package imufr_pkg;

    // Quaternion components are always 16 bits wide.
    localparam int QW = 16;
    localparam int SEQ_W = 32;

    // Configuration port: five registers at 4-byte spacing.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // 9.81 in Q16: 642908 / 65536.
    localparam int GRAV_W = 21;
    localparam logic signed [GRAV_W-1:0] GRAV_Q16 = 21'sd642908;
    localparam int GRAV_FRAC = 16;
    localparam int GRAV_HALF = 32768;

    typedef enum logic [2:0] {
        REG_EXT_QW     = 3'd0,
        REG_EXT_QX     = 3'd1,
        REG_EXT_QY     = 3'd2,
        REG_EXT_QZ     = 3'd3,
        REG_ACCEL_IN_G = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic                 accel_in_g;
    } t_cfg;

endpackage

[rtl/core/imu_frame_rotation_unit.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation unit
// Rotates one inertial sample into the mounting frame given by an extrinsic
// quaternion and renormalizes the orientation.
//
//   channel   signals                          direction  transfer when
//   request   start, busy, i_*_in              in         start && !busy
//   result    o_valid, o_*_out                 out        o_valid (1 cycle)
//   config    psel, penable, pwrite, paddr,    in/out     psel && penable &&
//             pwdata, prdata, pready                      pwrite
//
// A request may be issued every cycle; busy stays low. The result strobe
// rises once the request has passed the quaternion product, the 32-stage
// square root and the QUAT_FRAC_BITS+1 stage divider; the result is taken
// at the edge after the strobe rises.
// Reset is synchronous and clears only the valid bits and the registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module imu_frame_rotation_unit #(
    parameter int VEC_WIDTH = 32,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imufr_pkg::APB_AW-1:0]       paddr,
    input  logic [imufr_pkg::APB_DW-1:0]       pwdata,
    output logic [imufr_pkg::APB_DW-1:0]       prdata,
    output logic                               pready,
    input  logic signed [VEC_WIDTH-1:0]        i_acc_x_in,
    input  logic signed [VEC_WIDTH-1:0]        i_acc_y_in,
    input  logic signed [VEC_WIDTH-1:0]        i_acc_z_in,
    input  logic signed [VEC_WIDTH-1:0]        i_rate_x_in,
    input  logic signed [VEC_WIDTH-1:0]        i_rate_y_in,
    input  logic signed [VEC_WIDTH-1:0]        i_rate_z_in,
    input  logic signed [imufr_pkg::QW-1:0]    i_att_w_in,
    input  logic signed [imufr_pkg::QW-1:0]    i_att_x_in,
    input  logic signed [imufr_pkg::QW-1:0]    i_att_y_in,
    input  logic signed [imufr_pkg::QW-1:0]    i_att_z_in,
    input  logic [imufr_pkg::SEQ_W-1:0]        i_seq_in,
    output logic                               o_valid,
    output logic signed [VEC_WIDTH-1:0]        o_acc_x_out,
    output logic signed [VEC_WIDTH-1:0]        o_acc_y_out,
    output logic signed [VEC_WIDTH-1:0]        o_acc_z_out,
    output logic signed [VEC_WIDTH-1:0]        o_rate_x_out,
    output logic signed [VEC_WIDTH-1:0]        o_rate_y_out,
    output logic signed [VEC_WIDTH-1:0]        o_rate_z_out,
    output logic signed [imufr_pkg::QW-1:0]    o_att_w_out,
    output logic signed [imufr_pkg::QW-1:0]    o_att_x_out,
    output logic signed [imufr_pkg::QW-1:0]    o_att_y_out,
    output logic signed [imufr_pkg::QW-1:0]    o_att_z_out,
    output logic [imufr_pkg::SEQ_W-1:0]        o_seq_out
);

    import imufr_pkg::*;

    localparam int VW = VEC_WIDTH;
    // Stages after the input register: vector path and quaternion path.
    localparam int VEC_LAT = 4;
    localparam int QUAT_LAT = 39 + QUAT_FRAC_BITS;
    localparam int DLY = QUAT_LAT - VEC_LAT;
    localparam int DW = 6 * VW + SEQ_W;

    // ---------------- configuration registers -----------------------------
    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.qw         <= QW'(64'd1 << QUAT_FRAC_BITS);
            r_cfg.qx         <= '0;
            r_cfg.qy         <= '0;
            r_cfg.qz         <= '0;
            r_cfg.accel_in_g <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_EXT_QW:     r_cfg.qw <= pwdata[QW-1:0];
                REG_EXT_QX:     r_cfg.qx <= pwdata[QW-1:0];
                REG_EXT_QY:     r_cfg.qy <= pwdata[QW-1:0];
                REG_EXT_QZ:     r_cfg.qz <= pwdata[QW-1:0];
                REG_ACCEL_IN_G: r_cfg.accel_in_g <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_EXT_QW:     prdata = APB_DW'($unsigned(r_cfg.qw));
            REG_EXT_QX:     prdata = APB_DW'($unsigned(r_cfg.qx));
            REG_EXT_QY:     prdata = APB_DW'($unsigned(r_cfg.qy));
            REG_EXT_QZ:     prdata = APB_DW'($unsigned(r_cfg.qz));
            REG_ACCEL_IN_G: prdata = APB_DW'(r_cfg.accel_in_g);
            default:        prdata = '0;
        endcase
    end

    // ---------------- input register --------------------------------------
    logic                 r_v0;
    logic signed [VW-1:0] r_acc [3];
    logic signed [VW-1:0] r_rate [3];
    logic signed [QW-1:0] r_att [4];
    logic [SEQ_W-1:0]     r_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc[0]  <= i_acc_x_in;
        r_acc[1]  <= i_acc_y_in;
        r_acc[2]  <= i_acc_z_in;
        r_rate[0] <= i_rate_x_in;
        r_rate[1] <= i_rate_y_in;
        r_rate[2] <= i_rate_z_in;
        r_att[0]  <= i_att_w_in;
        r_att[1]  <= i_att_x_in;
        r_att[2]  <= i_att_y_in;
        r_att[3]  <= i_att_z_in;
        r_seq     <= i_seq_in;
    end

    // ---------------- vector path -----------------------------------------
    logic signed [VW-1:0] w_vacc [3];
    logic signed [VW-1:0] w_vrate [3];
    logic [SEQ_W-1:0]     w_vseq;
    logic [DW-1:0]        w_dly_in, w_dly_out;

    imufr_vec_rot #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_vec_rot (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .i_acc  (r_acc),
        .i_rate (r_rate),
        .i_seq  (r_seq),
        .o_acc  (w_vacc),
        .o_rate (w_vrate),
        .o_seq  (w_vseq)
    );

    assign w_dly_in = {w_vseq, w_vrate[2], w_vrate[1], w_vrate[0],
                       w_vacc[2], w_vacc[1], w_vacc[0]};

    imufr_delay #(
        .WIDTH (DW),
        .DEPTH (DLY)
    ) u_delay (
        .i_clk (i_clk),
        .i_d   (w_dly_in),
        .o_d   (w_dly_out)
    );

    assign o_acc_x_out  = w_dly_out[VW-1:0];
    assign o_acc_y_out  = w_dly_out[2*VW-1:VW];
    assign o_acc_z_out  = w_dly_out[3*VW-1:2*VW];
    assign o_rate_x_out = w_dly_out[4*VW-1:3*VW];
    assign o_rate_y_out = w_dly_out[5*VW-1:4*VW];
    assign o_rate_z_out = w_dly_out[6*VW-1:5*VW];
    assign o_seq_out    = w_dly_out[DW-1:6*VW];

    // ---------------- quaternion path -------------------------------------
    logic        w_qm_v;
    logic [63:0] w_qm_n2;
    logic [30:0] w_qm_mag [4];
    logic        w_qm_neg [4];
    logic signed [QW-1:0] w_att_out [4];

    imufr_quat_mul u_quat_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_v0),
        .i_att   (r_att),
        .o_valid (w_qm_v),
        .o_norm2 (w_qm_n2),
        .o_mag   (w_qm_mag),
        .o_neg   (w_qm_neg)
    );

    imufr_quat_norm #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_quat_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qm_v),
        .i_norm2 (w_qm_n2),
        .i_mag   (w_qm_mag),
        .i_neg   (w_qm_neg),
        .o_valid (o_valid),
        .o_att   (w_att_out)
    );

    assign o_att_w_out = w_att_out[0];
    assign o_att_x_out = w_att_out[1];
    assign o_att_y_out = w_att_out[2];
    assign o_att_z_out = w_att_out[3];

endmodule

[rtl/core/imufr_delay.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation delay line
// Fixed-depth register line that aligns the vector results with the
// quaternion normalization path.
// ----------------------------------------------------------------------------
module imufr_delay #(
    parameter int WIDTH = 224,
    parameter int DEPTH = 49
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_d = r_line[DEPTH-1];

endmodule

[rtl/core/imufr_vec_rot.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation vector path
// Gravity scaling of the acceleration and rotation of both vectors by the
// matrix of the extrinsic quaternion. Four register stages.
// ----------------------------------------------------------------------------
module imufr_vec_rot #(
    parameter int VEC_WIDTH = 32,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  imufr_pkg::t_cfg                i_cfg,
    input  logic signed [VEC_WIDTH-1:0]    i_acc [3],
    input  logic signed [VEC_WIDTH-1:0]    i_rate [3],
    input  logic [imufr_pkg::SEQ_W-1:0]    i_seq,
    output logic signed [VEC_WIDTH-1:0]    o_acc [3],
    output logic signed [VEC_WIDTH-1:0]    o_rate [3],
    output logic [imufr_pkg::SEQ_W-1:0]    o_seq
);

    import imufr_pkg::*;

    localparam int VW = VEC_WIDTH;
    localparam int F = QUAT_FRAC_BITS;
    localparam int E2W = ((2 * F > 32) ? 2 * F : 32) + 2;
    localparam int MW = E2W + 1 - F;
    localparam int PW = VW + MW;
    localparam int SW = PW + 2;
    localparam int GW = VW + GRAV_W;

    localparam logic signed [E2W-1:0] ONE = E2W'(1) << (2 * F);
    localparam logic signed [E2W:0] HALF_M = (E2W + 1)'(1) << (F - 1);
    localparam logic signed [SW-1:0] HALF_F = SW'(1) << (F - 1);

    // ---------------- matrix, tracks the configuration registers ----------
    logic signed [2*QW-1:0] r_yy, r_zz, r_xx, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [E2W-1:0]  w_e2 [9];
    logic signed [E2W:0]    w_mr [9];
    logic signed [MW-1:0]   r_m [9];

    always_ff @(posedge i_clk) begin
        r_yy <= (2*QW)'(i_cfg.qy) * (2*QW)'(i_cfg.qy);
        r_zz <= (2*QW)'(i_cfg.qz) * (2*QW)'(i_cfg.qz);
        r_xx <= (2*QW)'(i_cfg.qx) * (2*QW)'(i_cfg.qx);
        r_xy <= (2*QW)'(i_cfg.qx) * (2*QW)'(i_cfg.qy);
        r_wz <= (2*QW)'(i_cfg.qw) * (2*QW)'(i_cfg.qz);
        r_xz <= (2*QW)'(i_cfg.qx) * (2*QW)'(i_cfg.qz);
        r_wy <= (2*QW)'(i_cfg.qw) * (2*QW)'(i_cfg.qy);
        r_yz <= (2*QW)'(i_cfg.qy) * (2*QW)'(i_cfg.qz);
        r_wx <= (2*QW)'(i_cfg.qw) * (2*QW)'(i_cfg.qx);
    end

    always_comb begin
        w_e2[0] = ONE - ((E2W'(r_yy) + E2W'(r_zz)) <<< 1);
        w_e2[1] = (E2W'(r_xy) - E2W'(r_wz)) <<< 1;
        w_e2[2] = (E2W'(r_xz) + E2W'(r_wy)) <<< 1;
        w_e2[3] = (E2W'(r_xy) + E2W'(r_wz)) <<< 1;
        w_e2[4] = ONE - ((E2W'(r_xx) + E2W'(r_zz)) <<< 1);
        w_e2[5] = (E2W'(r_yz) - E2W'(r_wx)) <<< 1;
        w_e2[6] = (E2W'(r_xz) - E2W'(r_wy)) <<< 1;
        w_e2[7] = (E2W'(r_yz) + E2W'(r_wx)) <<< 1;
        w_e2[8] = ONE - ((E2W'(r_xx) + E2W'(r_yy)) <<< 1);
        for (int i = 0; i < 9; i++) begin
            w_mr[i] = (E2W + 1)'(w_e2[i]) + HALF_M;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_m[i] <= w_mr[i][E2W:F];
        end
    end

    // ---------------- stage 1: gravity product ----------------------------
    logic signed [GW-1:0] r_gp [3];
    logic signed [VW-1:0] r_acc1 [3];
    logic signed [VW-1:0] r_rate1 [3];
    logic [SEQ_W-1:0]     r_seq1;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_gp[i]    <= GW'(i_acc[i]) * GW'(GRAV_Q16);
            r_acc1[i]  <= i_acc[i];
            r_rate1[i] <= i_rate[i];
        end
        r_seq1 <= i_seq;
    end

    // ---------------- stage 2: round, negate, saturate --------------------
    logic signed [GW-1:0]         w_gt [3];
    logic signed [GW-GRAV_FRAC-1:0] w_gs [3];
    logic signed [VW+5:0]         w_gn [3];
    logic signed [VW-1:0]         w_gsat [3];
    logic signed [VW-1:0]         r_a2 [3];
    logic signed [VW-1:0]         r_rate2 [3];
    logic [SEQ_W-1:0]             r_seq2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_gt[i] = r_gp[i] + GW'(GRAV_HALF);
            w_gs[i] = w_gt[i][GW-1:GRAV_FRAC];
            w_gn[i] = -((VW + 6)'(w_gs[i]));
            if ((&w_gn[i][VW+5:VW-1]) || !(|w_gn[i][VW+5:VW-1])) begin
                w_gsat[i] = w_gn[i][VW-1:0];
            end else begin
                w_gsat[i] = {w_gn[i][VW+5], {(VW-1){~w_gn[i][VW+5]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a2[i]    <= i_cfg.accel_in_g ? w_gsat[i] : r_acc1[i];
            r_rate2[i] <= r_rate1[i];
        end
        r_seq2 <= r_seq1;
    end

    // ---------------- stage 3: matrix products ----------------------------
    logic signed [PW-1:0] r_pa [3][3];
    logic signed [PW-1:0] r_pr [3][3];
    logic [SEQ_W-1:0]     r_seq3;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_pa[i][j] <= PW'(r_a2[j]) * PW'(r_m[3*i+j]);
                r_pr[i][j] <= PW'(r_rate2[j]) * PW'(r_m[3*i+j]);
            end
        end
        r_seq3 <= r_seq2;
    end

    // ---------------- stage 4: row sums, round, saturate ------------------
    logic signed [SW-1:0]   w_sa [3];
    logic signed [SW-1:0]   w_sr [3];
    logic signed [SW-F-1:0] w_ha [3];
    logic signed [SW-F-1:0] w_hr [3];
    logic signed [VW-1:0]   w_oa [3];
    logic signed [VW-1:0]   w_or [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sa[i] = SW'(r_pa[i][0]) + SW'(r_pa[i][1]) + SW'(r_pa[i][2]) + HALF_F;
            w_sr[i] = SW'(r_pr[i][0]) + SW'(r_pr[i][1]) + SW'(r_pr[i][2]) + HALF_F;
            w_ha[i] = w_sa[i][SW-1:F];
            w_hr[i] = w_sr[i][SW-1:F];
            if ((&w_ha[i][SW-F-1:VW-1]) || !(|w_ha[i][SW-F-1:VW-1])) begin
                w_oa[i] = w_ha[i][VW-1:0];
            end else begin
                w_oa[i] = {w_ha[i][SW-F-1], {(VW-1){~w_ha[i][SW-F-1]}}};
            end
            if ((&w_hr[i][SW-F-1:VW-1]) || !(|w_hr[i][SW-F-1:VW-1])) begin
                w_or[i] = w_hr[i][VW-1:0];
            end else begin
                w_or[i] = {w_hr[i][SW-F-1], {(VW-1){~w_hr[i][SW-F-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            o_acc[i]  <= w_oa[i];
            o_rate[i] <= w_or[i];
        end
        o_seq <= r_seq3;
    end

endmodule

[rtl/core/imufr_quat_mul.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation quaternion product
// Hamilton product of the orientation with the extrinsic quaternion, scaled
// down by four, and the squared norm of the result. Four register stages.
// ----------------------------------------------------------------------------
module imufr_quat_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imufr_pkg::t_cfg                  i_cfg,
    input  logic                             i_valid,
    input  logic signed [imufr_pkg::QW-1:0]  i_att [4],
    output logic                             o_valid,
    output logic [63:0]                      o_norm2,
    output logic [30:0]                      o_mag [4],
    output logic                             o_neg [4]
);

    import imufr_pkg::*;

    logic signed [QW-1:0]   w_e [4];
    logic signed [2*QW-1:0] r_pp [4][4];
    logic signed [33:0]     w_p [4];
    logic signed [31:0]     r_r [4];
    logic signed [31:0]     w_abs [4];
    logic [61:0]            r_sq [4];
    logic [30:0]            r_mag3 [4];
    logic                   r_neg3 [4];
    logic                   r_v1, r_v2, r_v3;

    assign w_e[0] = i_cfg.qw;
    assign w_e[1] = i_cfg.qx;
    assign w_e[2] = i_cfg.qy;
    assign w_e[3] = i_cfg.qz;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_pp[i][j] <= (2*QW)'(i_att[i]) * (2*QW)'(w_e[j]);
            end
        end
    end

    always_comb begin
        w_p[0] = 34'(r_pp[0][0]) - 34'(r_pp[1][1]) - 34'(r_pp[2][2]) - 34'(r_pp[3][3]);
        w_p[1] = 34'(r_pp[0][1]) + 34'(r_pp[1][0]) + 34'(r_pp[2][3]) - 34'(r_pp[3][2]);
        w_p[2] = 34'(r_pp[0][2]) - 34'(r_pp[1][3]) + 34'(r_pp[2][0]) + 34'(r_pp[3][1]);
        w_p[3] = 34'(r_pp[0][3]) + 34'(r_pp[1][2]) - 34'(r_pp[2][1]) + 34'(r_pp[3][0]);
        for (int i = 0; i < 4; i++) begin
            w_abs[i] = r_r[i][31] ? -r_r[i] : r_r[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            // Dropping two bits is a floor divide by four.
            r_r[i]    <= w_p[i][33:2];
            r_mag3[i] <= w_abs[i][30:0];
            r_neg3[i] <= r_r[i][31];
            r_sq[i]   <= 62'(w_abs[i][30:0]) * 62'(w_abs[i][30:0]);
            o_mag[i]  <= r_mag3[i];
            o_neg[i]  <= r_neg3[i];
        end
        o_norm2 <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]) + 64'(r_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

endmodule

[rtl/core/imufr_quat_norm.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation quaternion normalizer
// Pipelined integer square root (one result bit per stage) followed by four
// pipelined restoring dividers that share the root as divisor.
// ----------------------------------------------------------------------------
module imufr_quat_norm #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [63:0]                      i_norm2,
    input  logic [30:0]                      i_mag [4],
    input  logic                             i_neg [4],
    output logic                             o_valid,
    output logic signed [imufr_pkg::QW-1:0]  o_att [4]
);

    import imufr_pkg::*;

    localparam int F = QUAT_FRAC_BITS;
    localparam int NL = F + 1;
    localparam int NW = 32 + F;
    localparam int SQ_STAGES = 32;

    // ---------------- square root -----------------------------------------
    logic [63:0] r_sq_n   [SQ_STAGES];
    logic [63:0] r_sq_res [SQ_STAGES];
    logic [30:0] r_sq_mag [SQ_STAGES][4];
    logic        r_sq_neg [SQ_STAGES][4];
    logic        r_sq_v   [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_n_in, w_res_in, w_try;
        logic [30:0] w_mag_in [4];
        logic        w_neg_in [4];
        logic        w_v_in;

        if (k == 0) begin : g_first
            assign w_n_in   = i_norm2;
            assign w_res_in = '0;
            assign w_mag_in = i_mag;
            assign w_neg_in = i_neg;
            assign w_v_in   = i_valid;
        end else begin : g_next
            assign w_n_in   = r_sq_n[k-1];
            assign w_res_in = r_sq_res[k-1];
            assign w_mag_in = r_sq_mag[k-1];
            assign w_neg_in = r_sq_neg[k-1];
            assign w_v_in   = r_sq_v[k-1];
        end

        assign w_try = w_res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (w_n_in >= w_try) begin
                r_sq_n[k]   <= w_n_in - w_try;
                r_sq_res[k] <= (w_res_in >> 1) + BIT;
            end else begin
                r_sq_n[k]   <= w_n_in;
                r_sq_res[k] <= w_res_in >> 1;
            end
            r_sq_mag[k] <= w_mag_in;
            r_sq_neg[k] <= w_neg_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else begin
                r_sq_v[k] <= w_v_in;
            end
        end
    end

    // ---------------- divider set-up --------------------------------------
    logic [31:0]   w_s;
    logic [NW-1:0] w_num [4];
    logic [31:0]   r_pr_rem [4];
    logic [NL-1:0] r_pr_nl [4];
    logic [31:0]   r_pr_s;
    logic          r_pr_zero;
    logic          r_pr_neg [4];
    logic          r_pr_v;

    assign w_s = r_sq_res[SQ_STAGES-1][31:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // Numerator carries the rounding term: (mag * 2^F + s / 2) / s.
            w_num[i] = (NW'(r_sq_mag[SQ_STAGES-1][i]) << F) + NW'(w_s >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_pr_rem[i] <= 32'(w_num[i][NW-1:NL]);
            r_pr_nl[i]  <= w_num[i][NL-1:0];
            r_pr_neg[i] <= r_sq_neg[SQ_STAGES-1][i];
        end
        r_pr_s    <= w_s;
        r_pr_zero <= (w_s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else begin
            r_pr_v <= r_sq_v[SQ_STAGES-1];
        end
    end

    // ---------------- restoring division, one quotient bit per stage ------
    logic [31:0]   r_dv_rem  [NL][4];
    logic [NL-1:0] r_dv_nl   [NL][4];
    logic [NL-1:0] r_dv_q    [NL][4];
    logic [31:0]   r_dv_s    [NL];
    logic          r_dv_zero [NL];
    logic          r_dv_neg  [NL][4];
    logic          r_dv_v    [NL];

    for (genvar j = 0; j < NL; j++) begin : g_div
        localparam int K = F - j;
        logic [31:0]   w_rem_in [4];
        logic [NL-1:0] w_nl_in  [4];
        logic [NL-1:0] w_q_in   [4];
        logic [31:0]   w_s_in;
        logic          w_zero_in;
        logic          w_neg_in [4];
        logic          w_v_in;
        logic [32:0]   w_t [4];

        if (j == 0) begin : g_first
            assign w_rem_in  = r_pr_rem;
            assign w_nl_in   = r_pr_nl;
            assign w_s_in    = r_pr_s;
            assign w_zero_in = r_pr_zero;
            assign w_neg_in  = r_pr_neg;
            assign w_v_in    = r_pr_v;
            for (genvar i = 0; i < 4; i++) begin : g_q0
                assign w_q_in[i] = '0;
            end
        end else begin : g_next
            assign w_rem_in  = r_dv_rem[j-1];
            assign w_nl_in   = r_dv_nl[j-1];
            assign w_q_in    = r_dv_q[j-1];
            assign w_s_in    = r_dv_s[j-1];
            assign w_zero_in = r_dv_zero[j-1];
            assign w_neg_in  = r_dv_neg[j-1];
            assign w_v_in    = r_dv_v[j-1];
        end

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                w_t[i] = {w_rem_in[i], w_nl_in[i][K]};
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 4; i++) begin
                if (w_t[i] >= {1'b0, w_s_in}) begin
                    r_dv_rem[j][i] <= 32'(w_t[i] - {1'b0, w_s_in});
                    r_dv_q[j][i]   <= w_q_in[i] | (NL'(1) << K);
                end else begin
                    r_dv_rem[j][i] <= w_t[i][31:0];
                    r_dv_q[j][i]   <= w_q_in[i];
                end
            end
            r_dv_nl[j]   <= w_nl_in;
            r_dv_s[j]    <= w_s_in;
            r_dv_zero[j] <= w_zero_in;
            r_dv_neg[j]  <= w_neg_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= w_v_in;
            end
        end
    end

    // ---------------- sign, clamp and zero-norm case ----------------------
    logic [31:0]        w_u [4];
    logic signed [QW-1:0] w_att [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_u[i] = 32'(r_dv_q[NL-1][i]);
            if (r_dv_zero[NL-1]) begin
                w_att[i] = '0;
            end else if (r_dv_neg[NL-1][i]) begin
                w_att[i] = (w_u[i] >= 32'h8000) ? 16'sh8000 : -$signed(w_u[i][QW-1:0]);
            end else begin
                w_att[i] = (w_u[i] > 32'h7FFF) ? 16'sh7FFF : $signed(w_u[i][QW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_att <= w_att;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv_v[NL-1];
        end
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// IMU frame rotation unit testbench
// Drives inertial samples under several extrinsic quaternion settings and
// checks every rotated result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import imufr_pkg::*;

    localparam int VW = 32;
    localparam int FB = 14;
    localparam int LATENCY_WAIT = 70;
    localparam int REG_UNMAPPED = 5;

    typedef struct {
        logic signed [VW-1:0]    vec [6];
        logic signed [QW-1:0]    att [4];
        logic        [SEQ_W-1:0] seq;
    } t_sample;

    class rotation_scoreboard;
        logic [QW-1:0] qw = 16'sd16384;
        logic [QW-1:0] qx = '0;
        logic [QW-1:0] qy = '0;
        logic [QW-1:0] qz = '0;
        bit            in_g = 1'b0;
        t_sample       pending [$];
        int            errors = 0;

        function void write_reg(int idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_EXT_QW:     qw = value[QW-1:0];
                REG_EXT_QX:     qx = value[QW-1:0];
                REG_EXT_QY:     qy = value[QW-1:0];
                REG_EXT_QZ:     qz = value[QW-1:0];
                REG_ACCEL_IN_G: in_g = value[0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int bits);
            longint hi, lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function t_sample rotate_sample(t_sample s);
            t_sample        res;
            longint         w, x, y, z, one, h, l, hsum, lsum, q;
            longint         e2 [9];
            longint         m [9];
            longint         v [6];
            longint         o [4];
            longint         p [4];
            longint         r [4];
            longint unsigned n, root, mag, u;
            w = longint'($signed(qw));
            x = longint'($signed(qx));
            y = longint'($signed(qy));
            z = longint'($signed(qz));
            one = longint'(1) << (2 * FB);
            e2[0] = one - 2 * (y * y + z * z);
            e2[1] = 2 * (x * y - w * z);
            e2[2] = 2 * (x * z + w * y);
            e2[3] = 2 * (x * y + w * z);
            e2[4] = one - 2 * (x * x + z * z);
            e2[5] = 2 * (y * z - w * x);
            e2[6] = 2 * (x * z - w * y);
            e2[7] = 2 * (y * z + w * x);
            e2[8] = one - 2 * (x * x + y * y);
            for (int i = 0; i < 9; i++) m[i] = (e2[i] + (longint'(1) << (FB - 1))) >>> FB;
            for (int i = 0; i < 6; i++) v[i] = longint'(s.vec[i]);
            // Gravity scaling rounds half up on the Q16 product before negation.
            if (in_g) begin
                for (int i = 0; i < 3; i++) begin
                    h = v[i] >>> GRAV_FRAC;
                    l = v[i] - (h << GRAV_FRAC);
                    v[i] = h * longint'(GRAV_Q16)
                         + ((l * longint'(GRAV_Q16) + GRAV_HALF) >>> GRAV_FRAC);
                    v[i] = clamp(-v[i], VW);
                end
            end
            for (int blk = 0; blk < 2; blk++) begin
                for (int row = 0; row < 3; row++) begin
                    hsum = 0;
                    lsum = 0;
                    for (int c = 0; c < 3; c++) begin
                        h = v[3 * blk + c] >>> FB;
                        l = v[3 * blk + c] - (h << FB);
                        hsum += h * m[3 * row + c];
                        lsum += l * m[3 * row + c];
                    end
                    res.vec[3 * blk + row] = VW'(clamp(hsum
                        + ((lsum + (longint'(1) << (FB - 1))) >>> FB), VW));
                end
            end
            for (int i = 0; i < 4; i++) o[i] = longint'(s.att[i]);
            p[0] = o[0] * w - o[1] * x - o[2] * y - o[3] * z;
            p[1] = o[0] * x + o[1] * w + o[2] * z - o[3] * y;
            p[2] = o[0] * y - o[1] * z + o[2] * w + o[3] * x;
            p[3] = o[0] * z + o[1] * y - o[2] * x + o[3] * w;
            n = 0;
            for (int i = 0; i < 4; i++) begin
                r[i] = p[i] >>> 2;
                n += longint'(r[i] * r[i]);
            end
            root = int_sqrt(n);
            for (int i = 0; i < 4; i++) begin
                q = 0;
                if (root != 0) begin
                    mag = r[i] < 0 ? -r[i] : r[i];
                    u = ((mag << FB) + root / 2) / root;
                    if (u > 64'h7FFF) u = 64'h7FFF + (r[i] < 0 ? 1 : 0);
                    q = r[i] < 0 ? -longint'(u) : longint'(u);
                end
                res.att[i] = QW'(clamp(q, QW));
            end
            res.seq = s.seq;
            return res;
        endfunction

        function void note_request(t_sample s);
            pending.push_back(rotate_sample(s));
        endfunction

        function void check_result(t_sample got);
            t_sample want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, seq %h", $time, got.seq);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 6; i++)
                if (got.vec[i] !== want.vec[i]) begin
                    $display("%0t: vector component %0d expected %h actual %h",
                             $time, i, want.vec[i], got.vec[i]);
                    errors++;
                end
            for (int i = 0; i < 4; i++)
                if (got.att[i] !== want.att[i]) begin
                    $display("%0t: attitude component %0d expected %h actual %h",
                             $time, i, want.att[i], got.att[i]);
                    errors++;
                end
            if (got.seq !== want.seq) begin
                $display("%0t: sequence expected %h actual %h", $time, want.seq, got.seq);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    psel, penable, pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic signed [VW-1:0]    vec_in [6];
    logic signed [QW-1:0]    att_in [4];
    logic [SEQ_W-1:0]        seq_in;
    logic                    o_valid;
    logic signed [VW-1:0]    vec_out [6];
    logic signed [QW-1:0]    att_out [4];
    logic [SEQ_W-1:0]        seq_out;

    rotation_scoreboard rot_sb = new();

    imu_frame_rotation_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_acc_x_in(vec_in[0]), .i_acc_y_in(vec_in[1]), .i_acc_z_in(vec_in[2]),
        .i_rate_x_in(vec_in[3]), .i_rate_y_in(vec_in[4]), .i_rate_z_in(vec_in[5]),
        .i_att_w_in(att_in[0]), .i_att_x_in(att_in[1]), .i_att_y_in(att_in[2]),
        .i_att_z_in(att_in[3]), .i_seq_in(seq_in),
        .o_valid(o_valid),
        .o_acc_x_out(vec_out[0]), .o_acc_y_out(vec_out[1]), .o_acc_z_out(vec_out[2]),
        .o_rate_x_out(vec_out[3]), .o_rate_y_out(vec_out[4]), .o_rate_z_out(vec_out[5]),
        .o_att_w_out(att_out[0]), .o_att_x_out(att_out[1]), .o_att_y_out(att_out[2]),
        .o_att_z_out(att_out[3]), .o_seq_out(seq_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        t_sample got;
        if (i_rst_n && o_valid) begin
            got.vec = vec_out;
            got.att = att_out;
            got.seq = seq_out;
            rot_sb.check_result(got);
        end
    end

    task automatic write_reg(int idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = APB_AW'(idx * 4);
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rot_sb.write_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (rot_sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic set_extrinsic(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] z, bit g);
        drain();
        write_reg(REG_EXT_QW, {16'h0, w});
        write_reg(REG_EXT_QX, {16'h0, x});
        write_reg(REG_EXT_QY, {16'h0, y});
        write_reg(REG_EXT_QZ, {16'h0, z});
        write_reg(REG_ACCEL_IN_G, {31'h0, g});
    endtask

    // Start stays high across back-to-back requests; it drops only for a gap.
    task automatic send_sample(t_sample s, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        vec_in = s.vec;
        att_in = s.att;
        seq_in = s.seq;
        do @(posedge i_clk); while (busy);
        rot_sb.note_request(s);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic [15:0] unit_component();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'(32'($urandom));
        if (pick == 1) return 16'(int'($urandom_range(0, 32768)) - 16384);
        return 16'(int'($urandom_range(0, 23170)) - 11585);
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        for (int i = 0; i < 6; i++)
            case ($urandom_range(0, 3))
                0: s.vec[i] = $urandom;
                1: s.vec[i] = int'($urandom_range(0, 2 << 20)) - (1 << 20);
                2: s.vec[i] = int'($urandom_range(0, 2 << 16)) - (1 << 16);
                default: s.vec[i] = int'($urandom_range(0, 2 << 24)) - (1 << 24);
            endcase
        for (int i = 0; i < 4; i++) s.att[i] = unit_component();
        if ($urandom_range(0, 40) == 0) s.att = '{16'h0, 16'h0, 16'h0, 16'h0};
        s.seq = $urandom;
        return s;
    endfunction

    function automatic t_sample directed_sample(int k);
        t_sample s;
        s = random_sample();
        case (k % 8)
            0: s.vec = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
            1: s.vec = '{32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000};
            2: s.vec = '{32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h0};
            default: ;
        endcase
        case (k % 6)
            0: s.att = '{16'h0, 16'h0, 16'h0, 16'h0};
            1: s.att = '{16'sd16384, 16'h0, 16'h0, 16'h0};
            2: s.att = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
            3: s.att = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
            4: s.att = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
            default: s.att = '{16'h0, 16'h0, 16'h0, 16'h1};
        endcase
        s.seq = (k % 3 == 0) ? 32'hFFFFFFFF : ((k % 3 == 1) ? 32'h0 : s.seq);
        return s;
    endfunction

    initial begin
        int gap;
        start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vec_in = '{default: '0};
        att_in = '{default: '0};
        seq_in = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, then gravity scaling with a 90 degree turn.
        for (int k = 0; k < 12; k++) send_sample(directed_sample(k), $urandom_range(0, 1));
        stop_sending();
        set_extrinsic(16'sd11585, 16'h0, 16'h0, 16'sd11585, 1'b1);
        for (int k = 0; k < 12; k++) send_sample(directed_sample(k + 3), 0);
        stop_sending();
        drain();
        // A write past the register map must leave the settings alone.
        write_reg(REG_UNMAPPED, 32'h0000_1234);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_extrinsic(16'sd16384, 16'h0, 16'h0, 16'h0, 1'b0);
                1: set_extrinsic(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
                2: set_extrinsic(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
                3: set_extrinsic(-16'sd16384, 16'h0, 16'sd16384, 16'h0, 1'b1);
                4: set_extrinsic(16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
                default: set_extrinsic(unit_component(), unit_component(),
                                       unit_component(), unit_component(),
                                       1'($urandom_range(0, 1)));
            endcase
            for (int k = 0; k < 160; k++) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if ((k / 40) % 2 == 1) gap = 0;
                send_sample(random_sample(), gap);
                if (phase == 3 && k == 80) begin
                    stop_sending();
                    while (rot_sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            stop_sending();
        end

        drain();
        if (rot_sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
